[hw/rtl/safs_pkg.sv]
// ----------------------------------------------------------------------------
// safs_pkg
// Shared field widths, angle constants and transaction types for the sprite
// animation frame stepper.
// ----------------------------------------------------------------------------
package safs_pkg;

   localparam int FRAME_W = 17;
   localparam int TOTAL_W = 8;
   localparam int FPS_W   = 8;
   localparam int TIME_W  = 16;
   localparam int ANGLE_W = 16;
   localparam int PROD_W  = TIME_W + FPS_W;

   localparam int FRAME_MAX = 65535;
   localparam int FRAME_MIN = -65536;

   // 360 degrees in 1/64 degree units, and twice that
   localparam logic [ANGLE_W-1:0] ANGLE_FULL = 16'd23040;
   localparam logic [ANGLE_W-1:0] ANGLE_TWICE = 16'd46080;

   typedef struct packed {
      logic signed [FRAME_W-1:0] frame_pos;
      logic                      backward;
      logic                      ended_in;
      logic [TOTAL_W-1:0]        frame_total;
      logic [FPS_W-1:0]          rate_fps;
      logic                      repeats;
      logic                      reverses;
      logic                      animated;
      logic [TIME_W-1:0]         elapsed;
      logic [ANGLE_W-1:0]        angle_in;
   } req_type;

   typedef struct packed {
      logic signed [FRAME_W-1:0] frame_out;
      logic                      backward_out;
      logic                      ended_out;
   } frame_res_type;

endpackage

[hw/rtl/safs_frame_step.sv]
// ----------------------------------------------------------------------------
// safs_frame_step
// Combinational frame advance: step from elapsed time and fps, end-of-strip
// handling (wrap, turn back or hold), mirroring at zero and saturation.
// ----------------------------------------------------------------------------
module safs_frame_step #(
   parameter int FRAME_FRAC_BITS = 8,
   parameter int TIME_FRAC_BITS  = 16
) (
   input  safs_pkg::req_type       item,
   output safs_pkg::frame_res_type res
);

   localparam int SHR   = (TIME_FRAC_BITS >= FRAME_FRAC_BITS) ?
                          (TIME_FRAC_BITS - FRAME_FRAC_BITS) : 0;
   localparam int SHL   = (FRAME_FRAC_BITS > TIME_FRAC_BITS) ?
                          (FRAME_FRAC_BITS - TIME_FRAC_BITS) : 0;
   localparam int DW    = safs_pkg::PROD_W + SHL;
   localparam int LIM_W = safs_pkg::TOTAL_W + FRAME_FRAC_BITS + 1;
   localparam int M1    = (DW > LIM_W) ? DW : LIM_W;
   localparam int M2    = (M1 > safs_pkg::FRAME_W) ? M1 : safs_pkg::FRAME_W;
   localparam int WW    = M2 + 2;

   localparam logic signed [WW-1:0] SAT_HI = WW'(safs_pkg::FRAME_MAX);
   localparam logic signed [WW-1:0] SAT_LO = WW'(safs_pkg::FRAME_MIN);
   localparam logic signed [WW-1:0] ONE    = WW'(1) << FRAME_FRAC_BITS;

   logic [safs_pkg::PROD_W-1:0] prod;
   logic [DW-1:0]               d_mag;
   logic signed [WW-1:0]        d_s;
   logic signed [WW-1:0]        f0;
   logic signed [WW-1:0]        f1;
   logic signed [WW-1:0]        f2;
   logic signed [WW-1:0]        f3;
   logic signed [WW-1:0]        limit;
   logic                        back;
   logic                        ended;

   always_comb begin
      prod  = {{safs_pkg::FPS_W{1'b0}}, item.elapsed}
            * {{safs_pkg::TIME_W{1'b0}}, item.rate_fps};
      d_mag = (DW'(prod) << SHL) >> SHR;
      d_s   = signed'({{(WW-DW){1'b0}}, d_mag});
      if (item.backward) begin
         d_s = -d_s;
      end
      f0    = WW'(item.frame_pos);
      limit = signed'(WW'(item.frame_total) << FRAME_FRAC_BITS);
      f1    = f0 + d_s;
      back  = item.backward;
      ended = item.ended_in;

      // end of strip
      f2 = f1;
      if (f1 >= limit) begin
         if (item.repeats) begin
            if (item.reverses) begin
               back = 1'b1;
               f2   = f0;
            end else begin
               f2 = f1 - limit;
            end
         end else begin
            f2    = limit - ONE;
            ended = 1'b1;
         end
      end

      // bounce off frame zero
      f3 = f2;
      if (f2 <= 0) begin
         if (item.reverses && back && !item.repeats) begin
            ended = 1'b1;
         end
         back = 1'b0;
         f3   = -f2;
      end

      if (!item.animated) begin
         res.frame_out    = item.frame_pos;
         res.backward_out = item.backward;
         res.ended_out    = item.ended_in;
      end else begin
         if (f3 > SAT_HI) begin
            res.frame_out = SAT_HI[safs_pkg::FRAME_W-1:0];
         end else if (f3 < SAT_LO) begin
            res.frame_out = SAT_LO[safs_pkg::FRAME_W-1:0];
         end else begin
            res.frame_out = f3[safs_pkg::FRAME_W-1:0];
         end
         res.backward_out = back;
         res.ended_out    = ended;
      end
   end

endmodule

[hw/rtl/safs_angle_wrap.sv]
// ----------------------------------------------------------------------------
// safs_angle_wrap
// Reduces an angle above one full turn modulo 360 degrees; a 16-bit angle
// is below three turns, so two compare-and-subtract choices cover it.
// ----------------------------------------------------------------------------
module safs_angle_wrap (
   input  logic [safs_pkg::ANGLE_W-1:0] angle_in,
   output logic [safs_pkg::ANGLE_W-1:0] angle_out
);

   always_comb begin
      if (angle_in >= safs_pkg::ANGLE_TWICE) begin
         angle_out = angle_in - safs_pkg::ANGLE_TWICE;
      end else if (angle_in > safs_pkg::ANGLE_FULL) begin
         angle_out = angle_in - safs_pkg::ANGLE_FULL;
      end else begin
         // exactly one full turn stays as it is
         angle_out = angle_in;
      end
   end

endmodule

[hw/rtl/sprite_anim_frame_stepper.sv]
// ----------------------------------------------------------------------------
// sprite_anim_frame_stepper
// Advances one sprite's animation frame, direction, ended flag and angle
// per transaction, with an input register and a result register.
// ----------------------------------------------------------------------------
//
//   channel | ports            | carries
//   --------+------------------+-----------------------------------------
//   req     | req_valid/stall  | frame, direction, class settings, lag
//   rsp     | rsp_valid/stall  | updated frame, direction, ended, angle
//
// one transaction per cycle sustained while rsp_stall stays low; an accepted
// transaction loads the input register, then the result register, and
// rsp_valid rises when the result register loads
// the whole frame path (16x8 multiply, add, compares) sits between the two
// registers; the angle reduction runs beside it
// synchronous active-high reset clears both valid flags only
// rsp_stall holds the result register; the input register keeps taking
// transactions while it is empty or the result register is free or being drained
//
module sprite_anim_frame_stepper #(
   parameter int FRAME_FRAC_BITS = 8,
   parameter int TIME_FRAC_BITS  = 16
) (
   input  logic                                clock,
   input  logic                                reset,

   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [safs_pkg::FRAME_W-1:0] req_frame_pos,
   input  logic                                req_backward,
   input  logic                                req_ended_in,
   input  logic [safs_pkg::TOTAL_W-1:0]        req_frame_total,
   input  logic [safs_pkg::FPS_W-1:0]          req_rate_fps,
   input  logic                                req_repeats,
   input  logic                                req_reverses,
   input  logic                                req_animated,
   input  logic [safs_pkg::TIME_W-1:0]         req_elapsed,
   input  logic [safs_pkg::ANGLE_W-1:0]        req_angle_in,

   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [safs_pkg::FRAME_W-1:0] rsp_frame_out,
   output logic                                rsp_backward_out,
   output logic                                rsp_ended_out,
   output logic [safs_pkg::ANGLE_W-1:0]        rsp_angle_out
);

   // input register
   logic                          s1_valid_ff;
   logic                          s1_valid_in;
   safs_pkg::req_type             s1_item_ff;
   safs_pkg::req_type             s1_item_in;

   // result register
   logic                          s2_valid_ff;
   logic                          s2_valid_in;
   safs_pkg::frame_res_type       s2_frame_ff;
   safs_pkg::frame_res_type       s2_frame_in;
   logic [safs_pkg::ANGLE_W-1:0]  s2_angle_ff;
   logic [safs_pkg::ANGLE_W-1:0]  s2_angle_in;

   logic                          s2_free;
   logic                          req_accept;

   // result register can load when empty or being taken this cycle
   assign s2_free    = !s2_valid_ff || !rsp_stall;
   // input register blocks only when full and unable to move on
   assign req_stall  = s1_valid_ff && !s2_free;
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      s1_item_in.frame_pos   = req_frame_pos;
      s1_item_in.backward    = req_backward;
      s1_item_in.ended_in    = req_ended_in;
      s1_item_in.frame_total = req_frame_total;
      s1_item_in.rate_fps    = req_rate_fps;
      s1_item_in.repeats     = req_repeats;
      s1_item_in.reverses    = req_reverses;
      s1_item_in.animated    = req_animated;
      s1_item_in.elapsed     = req_elapsed;
      s1_item_in.angle_in    = req_angle_in;
   end

   // stalled input register keeps its transaction, otherwise it takes the new one
   assign s1_valid_in = req_stall ? 1'b1 : req_valid;
   assign s2_valid_in = s2_free ? s1_valid_ff : s2_valid_ff;

   // frame math between the two registers
   safs_frame_step #(
      .FRAME_FRAC_BITS (FRAME_FRAC_BITS),
      .TIME_FRAC_BITS  (TIME_FRAC_BITS)
   ) u_frame_step (
      .item (s1_item_ff),
      .res  (s2_frame_in)
   );

   // angle reduction beside it
   safs_angle_wrap u_angle_wrap (
      .angle_in  (s1_item_ff.angle_in),
      .angle_out (s2_angle_in)
   );

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_item_ff <= s1_item_in;
      end
      if (s2_free && s1_valid_ff) begin
         s2_frame_ff <= s2_frame_in;
         s2_angle_ff <= s2_angle_in;
      end
   end

   assign rsp_valid        = s2_valid_ff;
   assign rsp_frame_out    = s2_frame_ff.frame_out;
   assign rsp_backward_out = s2_frame_ff.backward_out;
   assign rsp_ended_out    = s2_frame_ff.ended_out;
   assign rsp_angle_out    = s2_angle_ff;

   // ------------------------------------------------------------------------
   // assertions
   // ------------------------------------------------------------------------

   // a reduced angle never goes beyond one full turn
   a_angle_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_angle_out <= safs_pkg::ANGLE_FULL))
      else $error("angle out of range");

   // a held transaction in the input register is neither lost nor altered
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s2_valid_ff && rsp_stall)
      |=> (s1_valid_ff && $stable(s1_item_ff)))
      else $error("input register lost a stalled transaction");

   // a transaction in the input register moves into a free result register
   a_s2_load: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s2_free) |=> s2_valid_ff)
      else $error("result register missed a transaction");

endmodule
